### hw/rtl/mpt_pkg.sv
// Package of the max-pressure phase table: table sizes, derived widths,
// operation codes, the queued command record and the back-end state type.
// No dependencies.
package mpt_pkg;

    // table sizes
    localparam int LANE_SLOTS        = 32;
    localparam int CONN_SLOTS        = 64;
    localparam int PHASE_SLOTS       = 16;
    localparam int MEMBERS_PER_PHASE = 8;

    // derived widths
    localparam int LI_W  = (LANE_SLOTS > 1) ? $clog2(LANE_SLOTS) : 1;
    localparam int LU_W  = $clog2(LANE_SLOTS + 1);
    localparam int CI_W  = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
    localparam int CU_W  = $clog2(CONN_SLOTS + 1);
    localparam int PI_W  = (PHASE_SLOTS > 1) ? $clog2(PHASE_SLOTS) : 1;
    localparam int PU_W  = $clog2(PHASE_SLOTS + 1);
    localparam int MEM_DEPTH = PHASE_SLOTS * MEMBERS_PER_PHASE;
    localparam int MA_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int MS_W  = $clog2(MEMBERS_PER_PHASE + 1);

    // fixed field widths
    localparam int ID_W      = 32;
    localparam int CNT_W     = 16;
    localparam int SRC_W     = 5;
    localparam int CONN_W    = 6;
    localparam int PH_W      = 4;
    localparam int RES_IDX_W = 6;
    localparam int PRESS_W   = 20;

    localparam logic signed [PRESS_W-1:0] PRESS_FAIL = -20'sd9999;

    // function codes on the input port
    localparam logic [2:0] FUNC_ADD_LANE = 3'd0;
    localparam logic [2:0] FUNC_ADD_CONN = 3'd1;
    localparam logic [2:0] FUNC_OPEN     = 3'd2;
    localparam logic [2:0] FUNC_APPEND   = 3'd3;
    localparam logic [2:0] FUNC_SET_CNT  = 3'd4;
    localparam logic [2:0] FUNC_QUERY    = 3'd5;

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W = 1;
    localparam int QC_W = 2;

    typedef enum logic [2:0] {
        OP_ADD_LANE,
        OP_ADD_CONN,
        OP_OPEN,
        OP_APPEND,
        OP_SET_CNT,
        OP_QUERY,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   lane_id;
        logic [SRC_W-1:0]  src;
        logic [SRC_W-1:0]  tgt;
        logic [CONN_W-1:0] conn;
        logic [PH_W-1:0]   ph;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_L_CMP,
        ST_Q_SIZE,
        ST_Q_MEM,
        ST_Q_CONN,
        ST_Q_SRC,
        ST_Q_TGT
    } st_t;

endpackage

### hw/rtl/mpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/mpt_front.sv
// Front end: takes an item, decodes the function code and pre-computes
// the car count, then holds the command until the queue takes it.
// Depends on mpt_pkg.
module mpt_front
    import mpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        func,
    input  logic [ID_W-1:0]   lane_id,
    input  logic [SRC_W-1:0]  src_index,
    input  logic [SRC_W-1:0]  tgt_index,
    input  logic [CONN_W-1:0] conn_index,
    input  logic [PH_W-1:0]   phase_index,
    input  logic [7:0]        raw_byte,
    output logic              push,
    output cmd_t              push_cmd,
    input  logic              q_full
);

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    op_t  op_dec;
    logic take;

    // decode
    always_comb
    begin
        case (func)
            FUNC_ADD_LANE: op_dec = OP_ADD_LANE;
            FUNC_ADD_CONN: op_dec = OP_ADD_CONN;
            FUNC_OPEN:     op_dec = OP_OPEN;
            FUNC_APPEND:   op_dec = OP_APPEND;
            FUNC_SET_CNT:  op_dec = OP_SET_CNT;
            FUNC_QUERY:    op_dec = OP_QUERY;
            default:       op_dec = OP_BAD;
        endcase
    end

    assign push  = valid_reg && !q_full;
    assign busy  = valid_reg && q_full;
    assign take  = start && !busy;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next       = 1'b1;
            cmd_next.op      = op_dec;
            cmd_next.lane_id = lane_id;
            cmd_next.src     = src_index;
            cmd_next.tgt     = tgt_index;
            cmd_next.conn    = conn_index;
            cmd_next.ph      = phase_index;
            // a zero byte wraps to all ones
            cmd_next.count   = CNT_W'(raw_byte) - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

### hw/rtl/mpt_queue.sv
// Short command queue between front and back end.
// Depends on mpt_pkg.
module mpt_queue
    import mpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t pop_cmd
);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [QC_W-1:0]  cnt_reg, cnt_next;

    assign full    = (cnt_reg == QC_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_cmd = entry_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/mpt_back.sv
// Back end: executes queued commands against the lane, connection and
// phase tables held in RAMs, and issues one result per command.
// Depends on mpt_pkg and mpt_ram.
module mpt_back
    import mpt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  cmd_t                      q_cmd,
    output logic                      pop,
    output logic                      done,
    output logic                      status,
    output logic [RES_IDX_W-1:0]      index,
    output logic signed [PRESS_W-1:0] pressure
);

    st_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;

    logic [LU_W-1:0] lanes_used_reg, lanes_used_next;
    logic [CU_W-1:0] conns_used_reg, conns_used_next;
    logic [PU_W-1:0] phases_used_reg, phases_used_next;
    logic [MS_W-1:0] cur_size_reg, cur_size_next;

    logic [LI_W-1:0] li_reg, li_next;
    logic [MS_W-1:0] j_reg, j_next;
    logic [MS_W-1:0] n_reg, n_next;
    logic [MA_W-1:0] mbase_reg, mbase_next;
    logic [LI_W-1:0] tgt_reg, tgt_next;
    logic [CNT_W-1:0] scnt_reg, scnt_next;
    logic signed [PRESS_W-1:0] acc_reg, acc_next;

    logic done_reg, done_next;
    logic status_reg, status_next;
    logic [RES_IDX_W-1:0] index_reg, index_next;
    logic signed [PRESS_W-1:0] press_reg, press_next;

    // RAM ports
    logic             id_we;
    logic [LI_W-1:0]  id_waddr, id_raddr;
    logic [ID_W-1:0]  id_rdata;
    logic             cnt_we;
    logic [LI_W-1:0]  cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
    logic             cn_we;
    logic [CI_W-1:0]  cn_waddr, cn_raddr;
    logic [2*LI_W-1:0] cn_wdata, cn_rdata;
    logic             mb_we;
    logic [MA_W-1:0]  mb_waddr, mb_raddr;
    logic [CONN_W-1:0] mb_rdata;
    logic             sz_we;
    logic [PI_W-1:0]  sz_waddr, sz_raddr;
    logic [MS_W-1:0]  sz_wdata, sz_rdata;

    // shared conditions
    logic lanes_full, lanes_none, id_hit, search_last;
    logic conn_ok, open_ok, append_ok, query_ok;
    logic q_empty_phase, mem_skip, j_last;
    logic [MS_W-1:0] j_inc;

    assign lanes_full  = (lanes_used_reg == LU_W'(LANE_SLOTS));
    assign lanes_none  = (lanes_used_reg == '0);
    assign id_hit      = (id_rdata == cmd_reg.lane_id);
    assign search_last = ((LU_W'(li_reg) + LU_W'(1)) == lanes_used_reg);
    assign conn_ok     = (conns_used_reg != CU_W'(CONN_SLOTS))
                         && (32'(cmd_reg.src) < 32'(lanes_used_reg))
                         && (32'(cmd_reg.tgt) < 32'(lanes_used_reg));
    assign open_ok     = (phases_used_reg != PU_W'(PHASE_SLOTS));
    assign append_ok   = (phases_used_reg != '0)
                         && (cur_size_reg != MS_W'(MEMBERS_PER_PHASE));
    assign query_ok    = (32'(cmd_reg.ph) < 32'(phases_used_reg));
    assign q_empty_phase = (sz_rdata == '0);
    assign mem_skip    = (32'(mb_rdata) >= 32'(conns_used_reg));
    assign j_inc       = j_reg + MS_W'(1);
    assign j_last      = (j_inc == n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (cmd_reg.op == OP_ADD_LANE && !lanes_full && !lanes_none)
                begin
                    state_next = ST_L_CMP;
                end
                else if (cmd_reg.op == OP_SET_CNT && !lanes_none)
                begin
                    state_next = ST_L_CMP;
                end
                else if (cmd_reg.op == OP_QUERY && query_ok)
                begin
                    state_next = ST_Q_SIZE;
                end
            end
            ST_L_CMP:
            begin
                if (id_hit || search_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_SIZE:
            begin
                state_next = q_empty_phase ? ST_IDLE : ST_Q_MEM;
            end
            ST_Q_MEM:
            begin
                if (!mem_skip)
                begin
                    state_next = ST_Q_CONN;
                end
                else if (j_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_CONN: state_next = ST_Q_SRC;
            ST_Q_SRC:  state_next = ST_Q_TGT;
            ST_Q_TGT:  state_next = j_last ? ST_IDLE : ST_Q_MEM;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next         = cmd_reg;
        lanes_used_next  = lanes_used_reg;
        conns_used_next  = conns_used_reg;
        phases_used_next = phases_used_reg;
        cur_size_next    = cur_size_reg;
        li_next          = li_reg;
        j_next           = j_reg;
        n_next           = n_reg;
        mbase_next       = mbase_reg;
        tgt_next         = tgt_reg;
        scnt_next        = scnt_reg;
        acc_next         = acc_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        index_next       = index_reg;
        press_next       = press_reg;
        pop              = 1'b0;

        id_we     = 1'b0;
        id_waddr  = lanes_used_reg[LI_W-1:0];
        id_raddr  = li_reg;
        cnt_we    = 1'b0;
        cnt_waddr = li_reg;
        cnt_wdata = cmd_reg.count;
        cnt_raddr = cn_rdata[LI_W-1:0];
        cn_we     = 1'b0;
        cn_waddr  = conns_used_reg[CI_W-1:0];
        cn_wdata  = {LI_W'(cmd_reg.src), LI_W'(cmd_reg.tgt)};
        cn_raddr  = CI_W'(mb_rdata);
        mb_we     = 1'b0;
        mb_waddr  = MA_W'(32'(phases_used_reg - PU_W'(1)) * MEMBERS_PER_PHASE
                          + 32'(cur_size_reg));
        mb_raddr  = mbase_reg + MA_W'(j_reg);
        sz_we     = 1'b0;
        sz_waddr  = PI_W'(phases_used_reg);
        sz_wdata  = '0;
        sz_raddr  = PI_W'(cmd_reg.ph);

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                end
            end
            ST_EXEC:
            begin
                // default result: failure
                status_next = 1'b1;
                index_next  = '0;
                press_next  = '0;
                li_next     = '0;
                j_next      = '0;
                acc_next    = '0;
                mbase_next  = MA_W'(32'(cmd_reg.ph) * MEMBERS_PER_PHASE);
                id_raddr    = '0;
                case (cmd_reg.op)
                    OP_ADD_LANE:
                    begin
                        if (!lanes_full && lanes_none)
                        begin
                            // first lane: nothing to search
                            id_we           = 1'b1;
                            cnt_we          = 1'b1;
                            cnt_waddr       = '0;
                            cnt_wdata       = '0;
                            lanes_used_next = LU_W'(1);
                            status_next     = 1'b0;
                            done_next       = 1'b1;
                        end
                        else if (lanes_full)
                        begin
                            done_next = 1'b1;
                        end
                    end
                    OP_SET_CNT:
                    begin
                        if (lanes_none)
                        begin
                            done_next = 1'b1;
                        end
                    end
                    OP_ADD_CONN:
                    begin
                        done_next = 1'b1;
                        if (conn_ok)
                        begin
                            cn_we           = 1'b1;
                            conns_used_next = conns_used_reg + CU_W'(1);
                            status_next     = 1'b0;
                            index_next      = RES_IDX_W'(conns_used_reg);
                        end
                    end
                    OP_OPEN:
                    begin
                        done_next = 1'b1;
                        if (open_ok)
                        begin
                            sz_we            = 1'b1;
                            cur_size_next    = '0;
                            phases_used_next = phases_used_reg + PU_W'(1);
                            status_next      = 1'b0;
                            index_next       = RES_IDX_W'(phases_used_reg);
                        end
                    end
                    OP_APPEND:
                    begin
                        done_next = 1'b1;
                        if (append_ok)
                        begin
                            mb_we         = 1'b1;
                            sz_we         = 1'b1;
                            sz_waddr      = PI_W'(phases_used_reg - PU_W'(1));
                            sz_wdata      = cur_size_reg + MS_W'(1);
                            cur_size_next = cur_size_reg + MS_W'(1);
                            status_next   = 1'b0;
                            index_next    = RES_IDX_W'(phases_used_reg - PU_W'(1));
                        end
                    end
                    OP_QUERY:
                    begin
                        index_next = RES_IDX_W'(cmd_reg.ph);
                        if (!query_ok)
                        begin
                            press_next = PRESS_FAIL;
                            done_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            ST_L_CMP:
            begin
                // one stored id compared per cycle
                id_raddr = li_reg + LI_W'(1);
                li_next  = li_reg + LI_W'(1);
                if (id_hit)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    index_next  = RES_IDX_W'(li_reg);
                    if (cmd_reg.op == OP_SET_CNT)
                    begin
                        cnt_we = 1'b1;
                    end
                end
                else if (search_last)
                begin
                    done_next = 1'b1;
                    if (cmd_reg.op == OP_ADD_LANE)
                    begin
                        id_we           = 1'b1;
                        cnt_we          = 1'b1;
                        cnt_waddr       = lanes_used_reg[LI_W-1:0];
                        cnt_wdata       = '0;
                        lanes_used_next = lanes_used_reg + LU_W'(1);
                        status_next     = 1'b0;
                        index_next      = RES_IDX_W'(lanes_used_reg);
                    end
                end
            end
            ST_Q_SIZE:
            begin
                n_next = sz_rdata;
                if (q_empty_phase)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    press_next  = '0;
                end
            end
            ST_Q_MEM:
            begin
                // member naming an unused connection adds nothing
                if (mem_skip)
                begin
                    j_next   = j_inc;
                    mb_raddr = mbase_reg + MA_W'(j_inc);
                    if (j_last)
                    begin
                        done_next   = 1'b1;
                        status_next = 1'b0;
                        press_next  = acc_reg;
                    end
                end
            end
            ST_Q_CONN:
            begin
                tgt_next = cn_rdata[LI_W-1:0];
                cnt_raddr = cn_rdata[2*LI_W-1:LI_W];
            end
            ST_Q_SRC:
            begin
                scnt_next = cnt_rdata;
                cnt_raddr = tgt_reg;
            end
            ST_Q_TGT:
            begin
                acc_next = acc_reg + PRESS_W'(scnt_reg) - PRESS_W'(cnt_rdata);
                j_next   = j_inc;
                mb_raddr = mbase_reg + MA_W'(j_inc);
                if (j_last)
                begin
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    press_next  = acc_reg + PRESS_W'(scnt_reg) - PRESS_W'(cnt_rdata);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lanes_used_reg  <= '0;
            conns_used_reg  <= '0;
            phases_used_reg <= '0;
            cur_size_reg    <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lanes_used_reg  <= lanes_used_next;
            conns_used_reg  <= conns_used_next;
            phases_used_reg <= phases_used_next;
            cur_size_reg    <= cur_size_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        li_reg     <= li_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        mbase_reg  <= mbase_next;
        tgt_reg    <= tgt_next;
        scnt_reg   <= scnt_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        press_reg  <= press_next;
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign index    = index_reg;
    assign pressure = press_reg;

    // tables
    mpt_ram #(.WIDTH(ID_W), .DEPTH(LANE_SLOTS)) u_lane_ids (
        .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(cmd_reg.lane_id),
        .raddr(id_raddr), .rdata(id_rdata)
    );

    mpt_ram #(.WIDTH(CNT_W), .DEPTH(LANE_SLOTS)) u_lane_counts (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    mpt_ram #(.WIDTH(2*LI_W), .DEPTH(CONN_SLOTS)) u_conns (
        .clk(clk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
        .raddr(cn_raddr), .rdata(cn_rdata)
    );

    mpt_ram #(.WIDTH(CONN_W), .DEPTH(MEM_DEPTH)) u_members (
        .clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(cmd_reg.conn),
        .raddr(mb_raddr), .rdata(mb_rdata)
    );

    mpt_ram #(.WIDTH(MS_W), .DEPTH(PHASE_SLOTS)) u_sizes (
        .clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
        .raddr(sz_raddr), .rdata(sz_rdata)
    );

endmodule

### hw/rtl/max_pressure_phase_table.sv
// Top level of the max-pressure phase table: front end, command queue and
// back end. Depends on mpt_pkg, mpt_front, mpt_queue and mpt_back.
//
//  channel  | handshake      | fields
//  ---------+----------------+----------------------------------------------
//  command  | start / busy   | func lane_id src_index tgt_index conn_index
//           |                | phase_index raw_byte
//  result   | done (strobe)  | status index pressure
//
// Timing: with the back end idle, most operations pass the front register,
// the queue, ST_IDLE and ST_EXEC before done rises. A lane search compares
// one stored lane per cycle (up to LANE_SLOTS). A query reads the size,
// then steps each member (up to MEMBERS_PER_PHASE) from ST_Q_MEM to ST_Q_TGT,
// or ST_Q_MEM alone for an unused connection; each table RAM has one read port.
// Reset clears the usage counters and the queue; table contents need no clearing.
// busy rises when the front register and the two-entry queue are full.
// Results are shown for one cycle; the receiver cannot stall.
module max_pressure_phase_table
    import mpt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                func,
    input  logic [ID_W-1:0]           lane_id,
    input  logic [SRC_W-1:0]          src_index,
    input  logic [SRC_W-1:0]          tgt_index,
    input  logic [CONN_W-1:0]         conn_index,
    input  logic [PH_W-1:0]           phase_index,
    input  logic [7:0]                raw_byte,
    output logic                      done,
    output logic                      status,
    output logic [RES_IDX_W-1:0]      index,
    output logic signed [PRESS_W-1:0] pressure
);

    logic push, q_full, q_empty, pop;
    cmd_t push_cmd, q_cmd;

    mpt_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .lane_id(lane_id), .src_index(src_index),
        .tgt_index(tgt_index), .conn_index(conn_index),
        .phase_index(phase_index), .raw_byte(raw_byte),
        .push(push), .push_cmd(push_cmd), .q_full(q_full)
    );

    mpt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd),
        .full(q_full), .pop(pop), .empty(q_empty), .pop_cmd(q_cmd)
    );

    mpt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_cmd(q_cmd),
        .pop(pop), .done(done), .status(status), .index(index),
        .pressure(pressure)
    );

endmodule
